>>> hdl/ialu_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ialu_pkg
// Operation codes, widths and pipeline word layout for the 64-bit integer ALU.
// ----------------------------------------------------------------------------
package ialu_pkg;

   localparam int unsigned DataWidth = 64;
   localparam int unsigned HalfWidth = 32;
   localparam int unsigned KindWidth = 5;

   typedef logic [DataWidth-1:0] data_type;
   typedef logic [HalfWidth-1:0] half_type;

   typedef enum logic [KindWidth-1:0] {
      OP_ADD    = 5'd0,
      OP_SUB    = 5'd1,
      OP_MUL    = 5'd2,
      OP_AND    = 5'd3,
      OP_OR     = 5'd4,
      OP_XOR    = 5'd5,
      OP_NOT    = 5'd6,
      OP_SHL32  = 5'd7,
      OP_SHL64  = 5'd8,
      OP_SHR32  = 5'd9,
      OP_SHR64  = 5'd10,
      OP_SAR32  = 5'd11,
      OP_SAR64  = 5'd12,
      OP_ROTR32 = 5'd13,
      OP_ROTR64 = 5'd14,
      OP_ROTL32 = 5'd15,
      OP_ROTL64 = 5'd16,
      OP_EXT8S  = 5'd17,
      OP_EXT16S = 5'd18,
      OP_EXT8U  = 5'd19,
      OP_EXT16U = 5'd20,
      OP_EXT32S = 5'd21,
      OP_EXT32U = 5'd22
   } op_type;

   // Middle stage word: either a finished result or the multiply partials.
   typedef struct packed {
      logic     is_mul;
      logic     unknown;
      data_type result;
      data_type prod_low;
      half_type cross_a;
      half_type cross_b;
   } mid_type;

endpackage
`default_nettype wire

>>> hdl/integer_alu_fold.sv
`timescale 1ns / 1ps
`default_nettype none
// Pipeline: an accepted req word passes the input register, the middle register
// after the 32x32 multiplier partials and the result register to its rsp word.
// Throughput: one word per cycle while rsp_tready is high; each stage refills as it drains.
// Reset: synchronous, active high; clears the three stage valid flags only.
// ----------------------------------------------------------------------------
// integer_alu_fold
// Pipelined 64-bit integer ALU: arithmetic, logic, shifts, rotates, extends.
// ----------------------------------------------------------------------------
module integer_alu_fold (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               req_tvalid,
   output logic                                    req_tready,
   // [63:0] first_operand, [127:64] second_operand
   input  wire logic [2*ialu_pkg::DataWidth-1:0]   req_tdata,
   // [4:0] kind
   input  wire logic [ialu_pkg::KindWidth-1:0]     req_tuser,
   output logic                                    rsp_tvalid,
   input  wire logic                               rsp_tready,
   // [63:0] value
   output logic [ialu_pkg::DataWidth-1:0]          rsp_tdata,
   // [0] unknown_op
   output logic                                    rsp_tuser
);
   import ialu_pkg::*;

   // stage 1: input register
   logic     in_valid_ff;
   op_type   kind_ff;
   data_type a_ff, b_ff;
   // stage 2: middle register
   logic     mid_valid_ff;
   mid_type  mid_ff, mid_in;
   // stage 3: result register
   logic     out_valid_ff;
   data_type value_ff, value_in;
   logic     unknown_ff;

   logic load_out, load_mid, load_in;

   assign load_out   = mid_valid_ff && (!out_valid_ff || rsp_tready);
   assign load_mid   = in_valid_ff && (!mid_valid_ff || load_out);
   assign req_tready = !in_valid_ff || load_mid;
   assign load_in    = req_tvalid && req_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         mid_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (!mid_valid_ff || load_out) begin
            mid_valid_ff <= in_valid_ff;
         end
         if (!out_valid_ff || rsp_tready) begin
            out_valid_ff <= mid_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (load_in) begin
         kind_ff <= op_type'(req_tuser);
         a_ff    <= req_tdata[DataWidth-1:0];
         b_ff    <= req_tdata[2*DataWidth-1:DataWidth];
      end
      if (load_mid) begin
         mid_ff <= mid_in;
      end
      if (load_out) begin
         value_ff   <= value_in;
         unknown_ff <= mid_ff.unknown;
      end
   end

   // ---- stage 2 logic ----
   half_type               a_lo, a_hi, b_lo, b_hi;
   logic [4:0]             n32;
   logic [5:0]             n64;
   logic [2*DataWidth-1:0] a_dbl;
   logic [2*HalfWidth-1:0] a_lo_dbl;
   data_type               a_sx32;

   always_comb begin
      a_lo         = a_ff[HalfWidth-1:0];
      a_hi         = a_ff[DataWidth-1:HalfWidth];
      b_lo         = b_ff[HalfWidth-1:0];
      b_hi         = b_ff[DataWidth-1:HalfWidth];
      n32          = b_ff[4:0];
      n64          = b_ff[5:0];
      a_dbl        = {a_ff, a_ff};
      a_lo_dbl     = {a_lo, a_lo};
      a_sx32       = {{HalfWidth{a_lo[HalfWidth-1]}}, a_lo};

      mid_in          = '0;
      mid_in.prod_low = data_type'(a_lo) * data_type'(b_lo);
      // only the low half of each cross product reaches the low 64 bits
      mid_in.cross_a  = a_lo * b_hi;
      mid_in.cross_b  = a_hi * b_lo;

      case (kind_ff)
         OP_ADD:    mid_in.result = a_ff + b_ff;
         OP_SUB:    mid_in.result = a_ff - b_ff;
         OP_MUL:    mid_in.is_mul = 1'b1;
         OP_AND:    mid_in.result = a_ff & b_ff;
         OP_OR:     mid_in.result = a_ff | b_ff;
         OP_XOR:    mid_in.result = a_ff ^ b_ff;
         OP_NOT:    mid_in.result = ~a_ff;
         OP_SHL32:  mid_in.result = {{HalfWidth{1'b0}}, half_type'(a_lo << n32)};
         OP_SHL64:  mid_in.result = a_ff << n64;
         OP_SHR32:  mid_in.result = {{HalfWidth{1'b0}}, half_type'(a_lo >> n32)};
         OP_SHR64:  mid_in.result = a_ff >> n64;
         OP_SAR32:  mid_in.result = data_type'($signed(a_sx32) >>> n32);
         OP_SAR64:  mid_in.result = data_type'($signed(a_ff) >>> n64);
         // rotate as a shift of the doubled word; a zero count falls out naturally
         OP_ROTR32: mid_in.result = {{HalfWidth{1'b0}}, half_type'(a_lo_dbl >> n32)};
         OP_ROTR64: mid_in.result = data_type'(a_dbl >> n64);
         OP_ROTL32: begin
            mid_in.result = {{HalfWidth{1'b0}},
                             half_type'((a_lo_dbl << n32) >> HalfWidth)};
         end
         OP_ROTL64: mid_in.result = data_type'((a_dbl << n64) >> DataWidth);
         OP_EXT8S:  mid_in.result = {{(DataWidth-8){a_ff[7]}}, a_ff[7:0]};
         OP_EXT16S: mid_in.result = {{(DataWidth-16){a_ff[15]}}, a_ff[15:0]};
         OP_EXT8U:  mid_in.result = {{(DataWidth-8){1'b0}}, a_ff[7:0]};
         OP_EXT16U: mid_in.result = {{(DataWidth-16){1'b0}}, a_ff[15:0]};
         OP_EXT32S: mid_in.result = a_sx32;
         OP_EXT32U: mid_in.result = {{HalfWidth{1'b0}}, a_lo};
         default:   mid_in.unknown = 1'b1;
      endcase
   end

   // ---- stage 3 logic: fold the multiply partials ----
   half_type cross_sum;

   always_comb begin
      cross_sum = mid_ff.cross_a + mid_ff.cross_b;
      if (mid_ff.is_mul) begin
         value_in = mid_ff.prod_low + {cross_sum, {HalfWidth{1'b0}}};
      end else begin
         value_in = mid_ff.result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = value_ff;
   assign rsp_tuser  = unknown_ff;

   // ---- assertions ----
   a_unknown_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser |-> rsp_tdata == '0)
      else $error("unknown op word carries nonzero value");

   a_mid_kind: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff |-> !(mid_ff.is_mul && mid_ff.unknown))
      else $error("middle word flagged both multiply and unknown");

   a_mid_hold: assert property (@(posedge clock) disable iff (reset)
      mid_valid_ff && !load_out |=> mid_valid_ff && $stable(mid_ff))
      else $error("middle stage changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid && !in_valid_ff && !mid_valid_ff)
      else $error("pipeline not empty after reset");

endmodule
`default_nettype wire

>>> tb/integer_alu_fold_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_alu_fold_test
// Self-checking bench for the pipelined 64-bit integer ALU. A directed table
// covers operand extremes, every opcode, count wrap, rotate by zero and the
// undefined opcodes. About 1400 random words follow. Both stream sides idle
// at random, and there is one long receiver hold-off and one drain pause.
// Every rsp word is checked field by field against a typed row value or an ALU predictor.
// ----------------------------------------------------------------------------
module integer_alu_fold_test;
   import ialu_pkg::*;

   localparam logic [KindWidth-1:0] UNDEF_LOW  = 5'd23;
   localparam logic [KindWidth-1:0] UNDEF_HIGH = 5'd31;
   localparam data_type ALL_ONES = {DataWidth{1'b1}};
   localparam int RANDOM_WORDS = 1400;
   localparam int HOLD_CYCLES  = 60;
   localparam int REPORT_LIMIT = 10;

   typedef struct packed {
      data_type value;
      logic     unknown_op;
   } alu_result_type;

   typedef struct packed {
      logic [KindWidth-1:0] kind;
      data_type             first;
      data_type             second;
      logic                 typed;
      data_type             value;
      logic                 unknown_op;
   } op_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_tvalid = 1'b0;
   logic req_tready;
   logic [2*DataWidth-1:0] req_tdata = '0;   // [63:0] first_operand, [127:64] second_operand
   logic [KindWidth-1:0] req_tuser = '0;     // [4:0] kind
   logic rsp_tvalid;
   logic rsp_tready = 1'b0;
   logic [DataWidth-1:0] rsp_tdata;          // [63:0] value
   logic rsp_tuser;                          // [0] unknown_op

   alu_result_type pending_results[$];
   int  failure_count = 0;
   bit  sender_idle_on = 1'b1;
   bit  receiver_idle_on = 1'b1;
   int  hold_ticket = 0;
   int  hold_served = 0;
   int  hold_left = 0;

   // Rows with typed=1 carry a result that reads straight off the opcode.
   op_row_type op_rows [26] = '{
      '{OP_ADD,    ALL_ONES, 64'd1, 1'b1, 64'd0, 1'b0},
      '{OP_SUB,    64'd0, 64'd1, 1'b1, ALL_ONES, 1'b0},
      '{OP_MUL,    ALL_ONES, ALL_ONES, 1'b1, 64'd1, 1'b0},
      '{OP_AND,    ALL_ONES, 64'h5555_5555_5555_5555, 1'b1, 64'h5555_5555_5555_5555, 1'b0},
      '{OP_OR,     64'd0, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'hAAAA_AAAA_AAAA_AAAA, 1'b0},
      '{OP_XOR,    ALL_ONES, 64'hAAAA_AAAA_AAAA_AAAA, 1'b1, 64'h5555_5555_5555_5555, 1'b0},
      '{OP_NOT,    64'd0, 64'h1234_5678_9ABC_DEF0, 1'b1, ALL_ONES, 1'b0},
      '{OP_SHL32,  64'hFFFF_FFFF_0000_0001, 64'd31, 1'b1, 64'h0000_0000_8000_0000, 1'b0},
      '{OP_SHL64,  64'd1, 64'd64, 1'b1, 64'd1, 1'b0},
      '{OP_SHR32,  ALL_ONES, 64'hFFFF_FFFF_FFFF_FFE0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
      '{OP_SHR64,  ALL_ONES, 64'd63, 1'b1, 64'd1, 1'b0},
      '{OP_SAR32,  64'h0000_0000_8000_0000, 64'd31, 1'b1, ALL_ONES, 1'b0},
      '{OP_SAR64,  64'h8000_0000_0000_0000, 64'd63, 1'b1, ALL_ONES, 1'b0},
      '{OP_ROTR32, 64'h1234_5678_9ABC_DEF0, 64'd0, 1'b1, 64'h0000_0000_9ABC_DEF0, 1'b0},
      '{OP_ROTR64, 64'h0123_4567_89AB_CDEF, 64'd64, 1'b1, 64'h0123_4567_89AB_CDEF, 1'b0},
      '{OP_ROTL32, 64'hDEAD_BEEF_CAFE_F00D, 64'd32, 1'b1, 64'h0000_0000_CAFE_F00D, 1'b0},
      '{OP_ROTL32, 64'h0000_0000_8000_0001, 64'd1, 1'b0, 64'd0, 1'b0},
      '{OP_ROTL64, 64'h8000_0000_0000_0001, 64'd4, 1'b0, 64'd0, 1'b0},
      '{OP_EXT8S,  64'h0000_0000_0000_0080, 64'd0, 1'b1, 64'hFFFF_FFFF_FFFF_FF80, 1'b0},
      '{OP_EXT16S, 64'hFFFF_FFFF_FFFF_7FFF, 64'd0, 1'b1, 64'h0000_0000_0000_7FFF, 1'b0},
      '{OP_EXT8U,  ALL_ONES, ALL_ONES, 1'b1, 64'h0000_0000_0000_00FF, 1'b0},
      '{OP_EXT16U, ALL_ONES, ALL_ONES, 1'b1, 64'h0000_0000_0000_FFFF, 1'b0},
      '{OP_EXT32S, 64'h0000_0000_8000_0000, 64'd0, 1'b0, 64'd0, 1'b0},
      '{OP_EXT32U, ALL_ONES, 64'd0, 1'b1, 64'h0000_0000_FFFF_FFFF, 1'b0},
      '{UNDEF_LOW,  ALL_ONES, ALL_ONES, 1'b1, 64'd0, 1'b1},
      '{UNDEF_HIGH, ALL_ONES, ALL_ONES, 1'b1, 64'd0, 1'b1}
   };

   integer_alu_fold DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser)
   );

   always #4 clock = ~clock;

   function automatic alu_result_type compute_alu(input logic [KindWidth-1:0] kind,
                                                  input data_type a, input data_type b);
      alu_result_type r;
      logic [4:0] n32;
      logic [5:0] n64;
      half_type lo;
      half_type t;
      logic [2*HalfWidth-1:0] lo_pair;
      logic [2*DataWidth-1:0] full_pair;
      n32 = b[4:0];
      n64 = b[5:0];
      lo = a[HalfWidth-1:0];
      lo_pair = {lo, lo};
      full_pair = {a, a};
      r.value = '0;
      r.unknown_op = 1'b0;
      case (kind)
         OP_ADD:    r.value = a + b;
         OP_SUB:    r.value = a - b;
         OP_MUL:    r.value = a * b;
         OP_AND:    r.value = a & b;
         OP_OR:     r.value = a | b;
         OP_XOR:    r.value = a ^ b;
         OP_NOT:    r.value = ~a;
         OP_SHL32: begin
            t = lo << n32;
            r.value = {32'h0, t};
         end
         OP_SHL64:  r.value = a << n64;
         OP_SHR32: begin
            t = lo >> n32;
            r.value = {32'h0, t};
         end
         OP_SHR64:  r.value = a >> n64;
         OP_SAR32: begin
            t = $signed(lo) >>> n32;
            r.value = {{32{t[31]}}, t};
         end
         OP_SAR64:  r.value = $signed(a) >>> n64;
         OP_ROTR32: begin
            lo_pair = lo_pair >> n32;
            r.value = {32'h0, lo_pair[31:0]};
         end
         OP_ROTR64: begin
            full_pair = full_pair >> n64;
            r.value = full_pair[63:0];
         end
         OP_ROTL32: begin
            lo_pair = lo_pair << n32;
            r.value = {32'h0, lo_pair[63:32]};
         end
         OP_ROTL64: begin
            full_pair = full_pair << n64;
            r.value = full_pair[127:64];
         end
         OP_EXT8S:  r.value = {{56{a[7]}}, a[7:0]};
         OP_EXT16S: r.value = {{48{a[15]}}, a[15:0]};
         OP_EXT8U:  r.value = {56'h0, a[7:0]};
         OP_EXT16U: r.value = {48'h0, a[15:0]};
         OP_EXT32S: r.value = {{32{a[31]}}, a[31:0]};
         OP_EXT32U: r.value = {32'h0, a[31:0]};
         default:   r.unknown_op = 1'b1;
      endcase
      return r;
   endfunction

   function automatic data_type random_operand();
      data_type v;
      case ($urandom_range(7))
         4: v = 64'($urandom_range(255));
         5: v = $urandom_range(1) ? ALL_ONES : 64'd0;
         6: v = 64'd1 << $urandom_range(63);
         7: v = {32'h0, 32'h8000_0000} ^ 64'($urandom_range(3)) ^ ({64{1'($urandom)}} << 32);
         default: v = {$urandom, $urandom};
      endcase
      return v;
   endfunction

   // Offer one word, hold it until accepted, then log its expected result.
   task automatic send_op(input logic [KindWidth-1:0] kind, input data_type a,
                          input data_type b, input alu_result_type want);
      while (sender_idle_on && $urandom_range(99) < 32) begin
         req_tvalid <= 1'b0;
         @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= kind;
      req_tdata <= {b, a};
      do @(posedge clock); while (!req_tready);
      pending_results.push_back(want);
      @(negedge clock);
   endtask

   task automatic report_mismatch(input string what, input alu_result_type want,
                                  input alu_result_type got);
      failure_count++;
      if (failure_count <= REPORT_LIMIT)
         $display("mismatch %s: expected value %h unknown_op %b, got value %h unknown_op %b",
                  what, want.value, want.unknown_op, got.value, got.unknown_op);
   endtask

   // Receiver: random idling, plus a long hold-off whenever a new ticket shows up.
   always @(negedge clock) begin
      if (hold_served != hold_ticket) begin
         hold_served = hold_ticket;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= !(receiver_idle_on && $urandom_range(99) < 32);
      end
   end

   always @(posedge clock) begin
      alu_result_type got;
      alu_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.value = rsp_tdata;
         got.unknown_op = rsp_tuser;
         if (pending_results.size() == 0) begin
            report_mismatch("unexpected word", '0, got);
         end else begin
            want = pending_results.pop_front();
            if (got.value !== want.value)
               report_mismatch("value", want, got);
            else if (got.unknown_op !== want.unknown_op)
               report_mismatch("unknown_op", want, got);
         end
      end
   end

   initial begin
      #2ms;
      $display("tb: failure");
      $finish;
   end

   initial begin
      logic [KindWidth-1:0] kind;
      data_type a;
      data_type b;
      alu_result_type want;

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (op_rows[i]) begin
         if (op_rows[i].typed)
            want = '{op_rows[i].value, op_rows[i].unknown_op};
         else
            want = compute_alu(op_rows[i].kind, op_rows[i].first, op_rows[i].second);
         send_op(op_rows[i].kind, op_rows[i].first, op_rows[i].second, want);
      end

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         // long stretch with no idling on either side; the hold-off falls inside it
         if (n == 400) begin
            sender_idle_on = 1'b0;
            receiver_idle_on = 1'b0;
         end
         if (n == 450)
            hold_ticket <= hold_ticket + 1;
         if (n == 700) begin
            sender_idle_on = 1'b1;
            receiver_idle_on = 1'b1;
         end
         // pause until the pipe drains
         if (n == 1000) begin
            req_tvalid <= 1'b0;
            while (pending_results.size() != 0) @(negedge clock);
         end
         if ($urandom_range(99) < 8)
            kind = 5'($urandom_range(UNDEF_HIGH, UNDEF_LOW));
         else
            kind = 5'($urandom_range(OP_EXT32U, OP_ADD));
         a = random_operand();
         if (kind >= OP_SHL32 && kind <= OP_ROTL64 && $urandom_range(1))
            b = 64'($urandom_range(70));
         else
            b = random_operand();
         send_op(kind, a, b, compute_alu(kind, a, b));
      end
      req_tvalid <= 1'b0;

      while (pending_results.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
      if (failure_count == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end

endmodule
